>>> sv/lcdc_pkg.sv
// Shared types, codes and defaults for the graphic LCD controller core.
// Used by lcdc_ctrl, lcdc_mem and graphic_lcd_controller_core; no dependencies.
package lcdc_pkg;

  // Default display memory geometry.
  localparam int PAGES_DEFAULT   = 8;
  localparam int COLUMNS_DEFAULT = 128;

  // Bus access kinds carried by the command field.
  typedef enum logic [1:0] {
    ACC_CMD_WR    = 2'd0,
    ACC_STATUS_RD = 2'd1,
    ACC_DATA_WR   = 2'd2,
    ACC_DATA_RD   = 2'd3
  } access_t;

  // Command byte codes; ranges are given by their first and last code.
  localparam logic [7:0] CMD_COL_LOW         = 8'h00;
  localparam logic [7:0] CMD_COL_LOW_LAST    = 8'h0F;
  localparam logic [7:0] CMD_COL_HIGH        = 8'h10;
  localparam logic [7:0] CMD_COL_HIGH_LAST   = 8'h1F;
  localparam logic [7:0] CMD_RES_RATIO       = 8'h20;
  localparam logic [7:0] CMD_RES_RATIO_LAST  = 8'h27;
  localparam logic [7:0] CMD_POWER           = 8'h28;
  localparam logic [7:0] CMD_POWER_LAST      = 8'h2F;
  localparam logic [7:0] CMD_START_LINE      = 8'h40;
  localparam logic [7:0] CMD_START_LINE_LAST = 8'h7F;
  localparam logic [7:0] CMD_VREF            = 8'h81;
  localparam logic [7:0] CMD_ADC_NORMAL      = 8'hA0;
  localparam logic [7:0] CMD_ADC_REVERSE     = 8'hA1;
  localparam logic [7:0] CMD_BIAS_LOW        = 8'hA2;
  localparam logic [7:0] CMD_BIAS_HIGH       = 8'hA3;
  localparam logic [7:0] CMD_ENTIRE_OFF      = 8'hA4;
  localparam logic [7:0] CMD_ENTIRE_ON       = 8'hA5;
  localparam logic [7:0] CMD_REVERSE_OFF     = 8'hA6;
  localparam logic [7:0] CMD_REVERSE_ON      = 8'hA7;
  localparam logic [7:0] CMD_IND_OFF         = 8'hAC;
  localparam logic [7:0] CMD_IND_ON          = 8'hAD;
  localparam logic [7:0] CMD_DISP_OFF        = 8'hAE;
  localparam logic [7:0] CMD_DISP_ON         = 8'hAF;
  localparam logic [7:0] CMD_PAGE            = 8'hB0;
  localparam logic [7:0] CMD_PAGE_LAST       = 8'hBF;
  localparam logic [7:0] CMD_COM_DIR         = 8'hC0;
  localparam logic [7:0] CMD_COM_DIR_LAST    = 8'hCF;
  localparam logic [7:0] CMD_RMW_START       = 8'hE0;
  localparam logic [7:0] CMD_RESET           = 8'hE2;
  localparam logic [7:0] CMD_RMW_END         = 8'hEE;

  // Last column value; the column pointer stops here.
  localparam logic [7:0] COLUMN_MAX = 8'hFF;

  // Display settings held by the controller.
  typedef struct packed {
    logic       display_on;
    logic       entire_on;
    logic       reverse_video;
    logic       adc_reverse;
    logic       com_reverse;
    logic [5:0] start_line;
    logic       bias_select;
    logic [2:0] power_control;
    logic [2:0] resistor_ratio;
    logic [5:0] ref_voltage;
    logic       indicator_on;
    logic [1:0] indicator_blink;
  } settings_t;

  localparam settings_t SETTINGS_RESET = '{
    display_on:      1'b0,
    entire_on:       1'b0,
    reverse_video:   1'b0,
    adc_reverse:     1'b0,
    com_reverse:     1'b0,
    start_line:      6'd0,
    bias_select:     1'b0,
    power_control:   3'd0,
    resistor_ratio:  3'd0,
    ref_voltage:     6'd32,
    indicator_on:    1'b0,
    indicator_blink: 2'd0
  };

  // Display memory request for one transaction.
  typedef struct packed {
    logic       wr;        // data write
    logic       rd;        // data read, reloads the latch
    logic       in_range;  // page and column inside the memory
    logic       clear;     // reset command clears the latch
    logic [7:0] wdata;
  } mem_req_t;

endpackage

>>> sv/lcdc_ctrl.sv
// Command decoder and register file: pointers, pending argument, read-modify-write
// and display settings. Depends on lcdc_pkg.
module lcdc_ctrl
  import lcdc_pkg::*;
#(
  parameter int PAGES   = PAGES_DEFAULT,
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ADDR_W  = $clog2(PAGES * COLUMNS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [1:0]        command,
  input  logic [7:0]        bus_byte,
  output settings_t         settings,
  output mem_req_t          req,
  output logic [ADDR_W-1:0] addr
);

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_VREF,
    PEND_IND
  } pend_t;

  logic [3:0] page_ptr, page_ptr_next;
  logic [7:0] col_ptr, col_ptr_next;
  logic [7:0] saved_col, saved_col_next;
  logic       modify, modify_next;
  pend_t      pend, pend_next;
  settings_t  settings_next;
  logic [7:0] col_adv;
  logic       in_range;

  // Address of the current page and column.
  assign in_range = (page_ptr < 4'(PAGES)) && (col_ptr < 8'(COLUMNS));
  assign addr     = ADDR_W'(({8'd0, page_ptr} * 12'(COLUMNS)) + {4'd0, col_ptr});
  assign col_adv  = (col_ptr == COLUMN_MAX) ? col_ptr : col_ptr + 8'd1;

  // Next state for one transaction.
  always_comb begin
    page_ptr_next  = page_ptr;
    col_ptr_next   = col_ptr;
    saved_col_next = saved_col;
    modify_next    = modify;
    pend_next      = pend;
    settings_next  = settings;
    req            = '0;
    req.in_range   = in_range;
    req.wdata      = bus_byte;
    if (fire) begin
      unique case (access_t'(command))
        ACC_CMD_WR: begin
          if (pend == PEND_VREF) begin
            settings_next.ref_voltage = bus_byte[5:0];
            pend_next = PEND_NONE;
          end else if (pend == PEND_IND) begin
            settings_next.indicator_blink = bus_byte[1:0];
            pend_next = PEND_NONE;
          end else begin
            unique case (bus_byte) inside
              [CMD_COL_LOW:CMD_COL_LOW_LAST]: col_ptr_next = {col_ptr[7:4], bus_byte[3:0]};
              [CMD_COL_HIGH:CMD_COL_HIGH_LAST]: col_ptr_next = {bus_byte[3:0], col_ptr[3:0]};
              [CMD_RES_RATIO:CMD_RES_RATIO_LAST]: settings_next.resistor_ratio = bus_byte[2:0];
              [CMD_POWER:CMD_POWER_LAST]: settings_next.power_control = bus_byte[2:0];
              [CMD_START_LINE:CMD_START_LINE_LAST]: settings_next.start_line = bus_byte[5:0];
              CMD_VREF: pend_next = PEND_VREF;
              [CMD_ADC_NORMAL:CMD_ADC_REVERSE]: settings_next.adc_reverse = bus_byte[0];
              [CMD_BIAS_LOW:CMD_BIAS_HIGH]: settings_next.bias_select = bus_byte[0];
              [CMD_ENTIRE_OFF:CMD_ENTIRE_ON]: settings_next.entire_on = bus_byte[0];
              [CMD_REVERSE_OFF:CMD_REVERSE_ON]: settings_next.reverse_video = bus_byte[0];
              [CMD_IND_OFF:CMD_IND_ON]: begin
                settings_next.indicator_on = bus_byte[0];
                pend_next = PEND_IND;
              end
              [CMD_DISP_OFF:CMD_DISP_ON]: settings_next.display_on = bus_byte[0];
              [CMD_PAGE:CMD_PAGE_LAST]: page_ptr_next = bus_byte[3:0];
              [CMD_COM_DIR:CMD_COM_DIR_LAST]: settings_next.com_reverse = bus_byte[3];
              CMD_RMW_START: begin
                modify_next    = 1'b1;
                saved_col_next = col_ptr;
              end
              CMD_RMW_END: begin
                modify_next  = 1'b0;
                col_ptr_next = saved_col;
              end
              CMD_RESET: begin
                page_ptr_next  = '0;
                col_ptr_next   = '0;
                saved_col_next = '0;
                modify_next    = 1'b0;
                pend_next      = PEND_NONE;
                settings_next  = SETTINGS_RESET;
                req.clear      = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ACC_STATUS_RD: begin
        end
        ACC_DATA_WR: begin
          req.wr       = 1'b1;
          col_ptr_next = col_adv;
        end
        ACC_DATA_RD: begin
          req.rd = 1'b1;
          if (!modify) begin
            col_ptr_next = col_adv;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Register update.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_ptr  <= '0;
      col_ptr   <= '0;
      saved_col <= '0;
      modify    <= 1'b0;
      pend      <= PEND_NONE;
      settings  <= SETTINGS_RESET;
    end else begin
      page_ptr  <= page_ptr_next;
      col_ptr   <= col_ptr_next;
      saved_col <= saved_col_next;
      modify    <= modify_next;
      pend      <= pend_next;
      settings  <= settings_next;
    end
  end

endmodule

>>> sv/lcdc_mem.sv
// Display memory with its registered read port, which doubles as the read latch.
// Depends on lcdc_pkg for the request struct.
module lcdc_mem
  import lcdc_pkg::*;
#(
  parameter int DEPTH  = PAGES_DEFAULT * COLUMNS_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  mem_req_t          req,
  input  logic [ADDR_W-1:0] addr,
  output logic [7:0]        latch
);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  logic       latch_zero;

  // Single write or read per transaction; the read register holds the latch.
  always_ff @(posedge clk) begin
    if (req.wr && req.in_range) begin
      mem[addr] <= req.wdata;
    end
    if (req.rd && req.in_range) begin
      mem_q <= mem[addr];
    end
  end

  // The latch reads as zero after reset, after the reset command and after an
  // out-of-range read.
  always_ff @(posedge clk) begin
    if (rst) begin
      latch_zero <= 1'b1;
    end else if (req.clear) begin
      latch_zero <= 1'b1;
    end else if (req.rd) begin
      latch_zero <= !req.in_range;
    end
  end

  assign latch = latch_zero ? 8'd0 : mem_q;

endmodule

>>> sv/graphic_lcd_controller_core.sv
// Graphic LCD controller core: bus access in, read data and settings out.
// Depends on lcdc_pkg, lcdc_ctrl and lcdc_mem.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall   command, bus_byte
//   out      out_valid / out_stall read_data, display_on .. indicator_mode
//
// One access per cycle is taken unless stalled; its result shows in the next cycle.
// The rate is set by the single display memory port, used once per access.
// Reset leaves the display memory contents undefined until written.
// A stalled result holds the input stalled in the same cycle.
module graphic_lcd_controller_core
  import lcdc_pkg::*;
#(
  parameter int PAGES   = PAGES_DEFAULT,
  parameter int COLUMNS = COLUMNS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] bus_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       display_on,
  output logic       entire_on,
  output logic       reverse_video,
  output logic       adc_reverse,
  output logic       com_reverse,
  output logic [5:0] start_line,
  output logic       bias_select,
  output logic [2:0] power_control,
  output logic [2:0] resistor_ratio,
  output logic [5:0] ref_voltage,
  output logic [1:0] indicator_mode
);

  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              fire;
  settings_t         settings;
  mem_req_t          req;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        latch;

  // Handshake: the result register frees when its transaction is taken.
  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;

  lcdc_ctrl #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .command  (command),
    .bus_byte (bus_byte),
    .settings (settings),
    .req      (req),
    .addr     (addr)
  );

  lcdc_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .addr  (addr),
    .latch (latch)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Read data register: status byte, old latch, or zero on writes.
  always_ff @(posedge clk) begin
    if (fire) begin
      case (access_t'(command))
        ACC_STATUS_RD: read_data <= {1'b0, settings.adc_reverse, settings.display_on, 5'd0};
        ACC_DATA_RD:   read_data <= latch;
        default:       read_data <= 8'd0;
      endcase
    end
  end

  // Settings change only when a transaction is accepted, so they pair with read_data.
  assign display_on     = settings.display_on;
  assign entire_on      = settings.entire_on;
  assign reverse_video  = settings.reverse_video;
  assign adc_reverse    = settings.adc_reverse;
  assign com_reverse    = settings.com_reverse;
  assign start_line     = settings.start_line;
  assign bias_select    = settings.bias_select;
  assign power_control  = settings.power_control;
  assign resistor_ratio = settings.resistor_ratio;
  assign ref_voltage    = settings.ref_voltage;
  assign indicator_mode = settings.indicator_on ? settings.indicator_blink : 2'd0;

`ifndef SYNTHESIS
  // An accepted transaction always yields a result in the next cycle.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted transaction produced no result");

  // Writes return zero read data.
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    fire && (command == ACC_CMD_WR || command == ACC_DATA_WR) |=> read_data == 8'd0)
    else $error("write returned nonzero read data");

  // A status read reports the flags, which it does not change.
  a_status_bits: assert property (@(posedge clk) disable iff (rst)
    fire && command == ACC_STATUS_RD |=>
      read_data[7] == 1'b0 && read_data[4:0] == 5'd0 &&
      read_data[6] == adc_reverse && read_data[5] == display_on)
    else $error("status byte does not match settings");
`endif

endmodule

>>> verif/tb_graphic_lcd_controller_core.sv
// Self-checking testbench for graphic_lcd_controller_core: random and directed bus accesses,
// checked against an in-bench model of the page/column controller.
// Depends on lcdc_pkg and the graphic_lcd_controller_core RTL.
module tb_graphic_lcd_controller_core
  import lcdc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES         = PAGES_DEFAULT;
  localparam int COLUMNS       = COLUMNS_DEFAULT;
  localparam int ITEMS         = 1750;
  localparam int HOLD_AT       = 500;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int REPORT_LIMIT  = 10;

  // Which second byte a two-byte command is waiting for.
  typedef enum bit [1:0] {ARG_NONE, ARG_VREF, ARG_IND} arg_wait_t;

  // Everything the block presents with one result transaction.
  typedef struct {
    logic [7:0] read_data;
    logic       display_on;
    logic       entire_on;
    logic       reverse_video;
    logic       adc_reverse;
    logic       com_reverse;
    logic [5:0] start_line;
    logic       bias_select;
    logic [2:0] power_control;
    logic [2:0] resistor_ratio;
    logic [5:0] ref_voltage;
    logic [1:0] indicator_mode;
  } lcd_view_t;

  // Mirror of the controller state; it predicts each result and checks what arrives.
  class lcdc_mirror;
    logic [7:0] mem [PAGES*COLUMNS];
    bit         written [PAGES*COLUMNS];
    logic [3:0] page;
    logic [7:0] column;
    logic [7:0] latch;
    logic [7:0] saved_column;
    bit         rmw_active;
    arg_wait_t  arg_wait;
    settings_t  cfg;
    lcd_view_t  expected_views[$];
    int         mismatches;
    int         results_seen;

    function new();
      clear_registers();
    endfunction

    function void clear_registers();
      page = '0;
      column = '0;
      latch = '0;
      saved_column = '0;
      rmw_active = 0;
      arg_wait = ARG_NONE;
      cfg = SETTINGS_RESET;
    endfunction

    function bit in_range();
      return page < PAGES && column < COLUMNS;
    endfunction

    function int cell_index();
      return int'(page) * COLUMNS + int'(column);
    endfunction

    // A data read here would reload the latch from a never-written entry.
    function bit reload_undefined();
      return in_range() && !written[cell_index()];
    endfunction

    function void advance_column();
      if (column != COLUMN_MAX) column++;
    endfunction

    // Decode one command write, including the argument of a two-byte command.
    function void run_command(logic [7:0] b);
      if (arg_wait == ARG_VREF) begin
        cfg.ref_voltage = b[5:0];
        arg_wait = ARG_NONE;
      end else if (arg_wait == ARG_IND) begin
        cfg.indicator_blink = b[1:0];
        arg_wait = ARG_NONE;
      end else if (b <= CMD_COL_LOW_LAST) begin
        column[3:0] = b[3:0];
      end else if (b <= CMD_COL_HIGH_LAST) begin
        column[7:4] = b[3:0];
      end else if (b <= CMD_RES_RATIO_LAST) begin
        cfg.resistor_ratio = b[2:0];
      end else if (b <= CMD_POWER_LAST) begin
        cfg.power_control = b[2:0];
      end else if (b >= CMD_START_LINE && b <= CMD_START_LINE_LAST) begin
        cfg.start_line = b[5:0];
      end else if (b >= CMD_PAGE && b <= CMD_PAGE_LAST) begin
        page = b[3:0];
      end else if (b >= CMD_COM_DIR && b <= CMD_COM_DIR_LAST) begin
        cfg.com_reverse = b[3];
      end else begin
        case (b)
          CMD_VREF: arg_wait = ARG_VREF;
          CMD_ADC_NORMAL, CMD_ADC_REVERSE: cfg.adc_reverse = b[0];
          CMD_BIAS_LOW, CMD_BIAS_HIGH: cfg.bias_select = b[0];
          CMD_ENTIRE_OFF, CMD_ENTIRE_ON: cfg.entire_on = b[0];
          CMD_REVERSE_OFF, CMD_REVERSE_ON: cfg.reverse_video = b[0];
          CMD_IND_OFF, CMD_IND_ON: begin
            cfg.indicator_on = b[0];
            arg_wait = ARG_IND;
          end
          CMD_DISP_OFF, CMD_DISP_ON: cfg.display_on = b[0];
          CMD_RMW_START: begin
            rmw_active = 1;
            saved_column = column;
          end
          CMD_RMW_END: begin
            rmw_active = 0;
            column = saved_column;
          end
          CMD_RESET: clear_registers();
          default: ;
        endcase
      end
    endfunction

    // Apply one accepted bus access and queue the result it must produce.
    function void note_access(access_t acc, logic [7:0] b);
      lcd_view_t v;
      v.read_data = '0;
      case (acc)
        ACC_CMD_WR: run_command(b);
        ACC_STATUS_RD: v.read_data = {1'b0, cfg.adc_reverse, cfg.display_on, 5'b0};
        ACC_DATA_WR: begin
          if (in_range()) begin
            mem[cell_index()] = b;
            written[cell_index()] = 1;
          end
          advance_column();
        end
        default: begin
          // The old latch goes out; the latch then reloads from the current address.
          v.read_data = latch;
          latch = in_range() ? mem[cell_index()] : 8'h00;
          if (!rmw_active) advance_column();
        end
      endcase
      v.display_on     = cfg.display_on;
      v.entire_on      = cfg.entire_on;
      v.reverse_video  = cfg.reverse_video;
      v.adc_reverse    = cfg.adc_reverse;
      v.com_reverse    = cfg.com_reverse;
      v.start_line     = cfg.start_line;
      v.bias_select    = cfg.bias_select;
      v.power_control  = cfg.power_control;
      v.resistor_ratio = cfg.resistor_ratio;
      v.ref_voltage    = cfg.ref_voltage;
      v.indicator_mode = cfg.indicator_on ? cfg.indicator_blink : 2'b00;
      expected_views.push_back(v);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (act_val !== exp_val)
        flag($sformatf("result %0d %s: expected %h, actual %h",
                       results_seen, name, exp_val, act_val));
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_view(lcd_view_t act);
      lcd_view_t e;
      results_seen++;
      if (expected_views.size() == 0) begin
        flag($sformatf("result %0d arrived with nothing expected, read_data %h",
                       results_seen, act.read_data));
        return;
      end
      e = expected_views.pop_front();
      compare_field("read_data", e.read_data, act.read_data);
      compare_field("display_on", 8'(e.display_on), 8'(act.display_on));
      compare_field("entire_on", 8'(e.entire_on), 8'(act.entire_on));
      compare_field("reverse_video", 8'(e.reverse_video), 8'(act.reverse_video));
      compare_field("adc_reverse", 8'(e.adc_reverse), 8'(act.adc_reverse));
      compare_field("com_reverse", 8'(e.com_reverse), 8'(act.com_reverse));
      compare_field("start_line", 8'(e.start_line), 8'(act.start_line));
      compare_field("bias_select", 8'(e.bias_select), 8'(act.bias_select));
      compare_field("power_control", 8'(e.power_control), 8'(act.power_control));
      compare_field("resistor_ratio", 8'(e.resistor_ratio), 8'(act.resistor_ratio));
      compare_field("ref_voltage", 8'(e.ref_voltage), 8'(act.ref_voltage));
      compare_field("indicator_mode", 8'(e.indicator_mode), 8'(act.indicator_mode));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = ACC_CMD_WR;
  logic [7:0] bus_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       display_on;
  logic       entire_on;
  logic       reverse_video;
  logic       adc_reverse;
  logic       com_reverse;
  logic [5:0] start_line;
  logic       bias_select;
  logic [2:0] power_control;
  logic [2:0] resistor_ratio;
  logic [5:0] ref_voltage;
  logic [1:0] indicator_mode;

  lcdc_mirror mirror = new();
  lcd_view_t  seen_view;
  int         accesses_sent;
  int         quiet_cycles;
  bit         in_calm;
  bit         out_calm;
  bit         hold_request;

  graphic_lcd_controller_core #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .bus_byte       (bus_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .display_on     (display_on),
    .entire_on      (entire_on),
    .reverse_video  (reverse_video),
    .adc_reverse    (adc_reverse),
    .com_reverse    (com_reverse),
    .start_line     (start_line),
    .bias_select    (bias_select),
    .power_control  (power_control),
    .resistor_ratio (resistor_ratio),
    .ref_voltage    (ref_voltage),
    .indicator_mode (indicator_mode)
  );

  // Free-running clock, 12 ns period.
  always #6 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Offer one bus access and wait until the block takes it.
  task automatic send_access(access_t acc, logic [7:0] b);
    int gap;
    // Never let a data read reload the latch from an entry that was never written.
    if (acc == ACC_DATA_RD && mirror.reload_undefined()) begin
      acc = ACC_DATA_WR;
      b = 8'($urandom);
    end
    if ($urandom_range(0, 79) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= acc;
    bus_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.note_access(acc, b);
    accesses_sent++;
    if (accesses_sent == HOLD_AT) hold_request = 1;
  endtask

  task automatic send_command(logic [7:0] b);
    send_access(ACC_CMD_WR, b);
  endtask

  // Set page and column; the column nibbles go in either order.
  task automatic point_at(logic [3:0] pg, logic [7:0] col);
    send_command(CMD_PAGE | {4'h0, pg});
    if ($urandom_range(0, 1)) begin
      send_command(CMD_COL_HIGH | {4'h0, col[7:4]});
      send_command(CMD_COL_LOW | {4'h0, col[3:0]});
    end else begin
      send_command(CMD_COL_LOW | {4'h0, col[3:0]});
      send_command(CMD_COL_HIGH | {4'h0, col[7:4]});
    end
  endtask

  task automatic point_in_range(output logic [3:0] pg, output logic [7:0] col);
    pg  = 4'($urandom_range(0, PAGES - 1));
    col = 8'($urandom_range(0, COLUMNS - 1));
    point_at(pg, col);
  endtask

  // One setting command with random argument bits.
  task automatic send_setting();
    case ($urandom_range(0, 8))
      0: send_command(CMD_DISP_OFF | 8'($urandom_range(0, 1)));
      1: send_command(CMD_START_LINE | 8'($urandom_range(0, 63)));
      2: send_command(CMD_ADC_NORMAL | 8'($urandom_range(0, 1)));
      3: send_command(CMD_REVERSE_OFF | 8'($urandom_range(0, 1)));
      4: send_command(CMD_ENTIRE_OFF | 8'($urandom_range(0, 1)));
      5: send_command(CMD_BIAS_LOW | 8'($urandom_range(0, 1)));
      6: send_command(CMD_COM_DIR | 8'($urandom_range(0, 15)));
      7: send_command(CMD_POWER | 8'($urandom_range(0, 7)));
      default: send_command(CMD_RES_RATIO | 8'($urandom_range(0, 7)));
    endcase
  endtask

  // Results are checked as they are accepted.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_view = '{read_data: read_data, display_on: display_on, entire_on: entire_on,
                    reverse_video: reverse_video, adc_reverse: adc_reverse,
                    com_reverse: com_reverse, start_line: start_line,
                    bias_select: bias_select, power_control: power_control,
                    resistor_ratio: resistor_ratio, ref_voltage: ref_voltage,
                    indicator_mode: indicator_mode};
      mirror.check_view(seen_view);
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("graphic_lcd_controller_core regression: fail");
        $finish;
      end
    end
  end

  // Result side: random stalls, calm stretches, and one long hold-off.
  initial begin
    int len;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (hold_request) begin
        hold_request = 0;
        len = HOLD_CYCLES;
      end else begin
        len = out_calm ? 0 : idle_len();
      end
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: directed accesses, then random scenarios.
  initial begin
    logic [3:0] pg;
    logic [7:0] col;
    int         k;
    int         r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Every single-byte setting command at its far values, checked through the settings outputs.
    send_access(ACC_STATUS_RD, 8'hFF);
    send_command(CMD_DISP_ON);
    send_command(CMD_ADC_REVERSE);
    send_command(CMD_REVERSE_ON);
    send_command(CMD_ENTIRE_ON);
    send_command(CMD_BIAS_HIGH);
    send_command(CMD_COM_DIR | 8'h08);
    send_command(CMD_START_LINE_LAST);
    send_command(CMD_POWER_LAST);
    send_command(CMD_RES_RATIO_LAST);
    // Two-byte commands; a status read leaves the argument pending.
    send_command(CMD_VREF);
    send_access(ACC_STATUS_RD, 8'h00);
    send_command(8'hFF);
    send_command(CMD_IND_ON);
    send_command(8'h03);
    send_command(CMD_IND_OFF);
    // The reset code here is only an argument.
    send_command(CMD_RESET);
    // Out-of-range page and saturated column: the write is dropped, the read loads zero.
    send_command(CMD_PAGE_LAST);
    send_command(CMD_COL_HIGH_LAST);
    send_command(CMD_COL_LOW_LAST);
    send_access(ACC_DATA_WR, 8'h5A);
    send_access(ACC_DATA_RD, 8'h00);
    // Write, then read-modify-write over the same column with a dummy read first.
    point_at(4'h0, 8'h00);
    send_access(ACC_DATA_WR, 8'hFF);
    send_access(ACC_DATA_WR, 8'h00);
    send_command(CMD_COL_LOW);
    send_command(CMD_RMW_START);
    send_access(ACC_DATA_RD, 8'h00);
    send_access(ACC_DATA_RD, 8'hFF);
    send_access(ACC_DATA_WR, 8'hA5);
    send_command(CMD_RMW_END);
    send_command(CMD_RMW_END);
    send_command(CMD_RESET);
    send_command(8'h35);
    send_access(ACC_STATUS_RD, 8'h00);

    while (accesses_sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        // Write a run of bytes, then read it back starting with the dummy read.
        if ($urandom_range(0, 9) == 0) begin
          pg  = 4'($urandom_range(0, 15));
          col = 8'($urandom_range(0, 255));
          point_at(pg, col);
        end else begin
          point_in_range(pg, col);
        end
        k = $urandom_range(1, 12);
        repeat (k) send_access(ACC_DATA_WR, 8'($urandom));
        point_at(pg, col);
        repeat (k + 1) send_access(ACC_DATA_RD, 8'($urandom));
      end else if (r < 40) begin
        // Fill a stretch of memory.
        point_in_range(pg, col);
        repeat ($urandom_range(4, 24)) send_access(ACC_DATA_WR, 8'($urandom));
      end else if (r < 52) begin
        // Read-modify-write loop, sometimes started twice.
        point_in_range(pg, col);
        send_command(CMD_RMW_START);
        if ($urandom_range(0, 3) == 0) send_command(CMD_RMW_START);
        repeat ($urandom_range(1, 6)) begin
          send_access(ACC_DATA_RD, 8'($urandom));
          send_access(ACC_DATA_RD, 8'($urandom));
          send_access(ACC_DATA_WR, 8'($urandom));
        end
        send_command(CMD_RMW_END);
      end else if (r < 64) begin
        // Two-byte command with other accesses slipped in before the argument.
        case ($urandom_range(0, 2))
          0: send_command(CMD_VREF);
          1: send_command(CMD_IND_OFF);
          default: send_command(CMD_IND_ON);
        endcase
        repeat ($urandom_range(0, 2))
          send_access(access_t'($urandom_range(ACC_STATUS_RD, ACC_DATA_RD)), 8'($urandom));
        send_command(8'($urandom));
      end else if (r < 76) begin
        send_setting();
      end else if (r < 86) begin
        // Column near the top: runs into the saturation point.
        pg = 4'($urandom_range(0, 15));
        point_at(pg, {4'hF, 4'($urandom_range(0, 15))});
        repeat ($urandom_range(4, 20))
          send_access($urandom_range(0, 1) ? ACC_DATA_WR : ACC_DATA_RD, 8'($urandom));
      end else if (r < 98) begin
        // Unstructured noise.
        repeat ($urandom_range(1, 4))
          send_access(access_t'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        send_command(CMD_RESET);
      end
    end
    in_valid <= 1'b0;

    // Drain, then let the block run on to show anything extra.
    while (mirror.expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.expected_views.size() == 0) begin
      $display("graphic_lcd_controller_core regression: pass");
    end else begin
      $display("graphic_lcd_controller_core regression: fail");
    end
    $finish;
  end

endmodule
